### rtl/kci_pkg.sv
`timescale 1ns / 1ps
package kci_pkg;

	// one input beat: key write or curve evaluation
	typedef struct packed {
		logic               kind;
		logic [2:0]         key_slot;
		logic [15:0]        key_time;
		logic signed [15:0] key_value;
		logic [15:0]        time_ratio;
		logic signed [15:0] origin_value;
	} item_t;

	// one result beat
	typedef struct packed {
		logic signed [31:0] curve_result;
		logic               matched;
		logic [2:0]         matched_slot;
	} result_t;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic wr_key;
		logic scan_start;
		logic scan_next;
		logic take_match;
		logic mul1;
		logic div_start;
		logic fix_v;
		logic mul2;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_write;
		logic too_few;
		logic hit;
		logic last;
		logic direct;
		logic div_done;
	} status_t;

endpackage

### rtl/keyframe_curve_interpolator.sv
`timescale 1ns / 1ps
// keyframe curve evaluator for one particle channel
// item channel (item_valid / item_ready / item): kind 0 beats load a key slot
//   with key_time and key_value, kind 1 beats evaluate the curve at time_ratio
//   and scale the interpolated key value by origin_value
// result channel (result_valid / result_ready / result): exactly one beat per
//   item beat, in order; write beats and misses return all zeros
// active_keys_we / active_keys_wdata set the number of keys in use; write it
//   only while no item is in flight
// one item at a time: a key write, or an evaluation with fewer than two
//   keys, goes straight to the result; an evaluation scans the active keys
//   in order and, on a hit, takes the key directly or interpolates through
//   the multiply, the 32 step bit-serial divide and the fix-up; the next
//   item is taken in the cycle after the result is registered
// the result register holds its beat while result_ready is low; a new item is
//   still accepted and runs until its own result waits for the register
// reset clears the controller, the key count and the result valid; key slots
//   are not cleared and must be written before they are used
module keyframe_curve_interpolator #(
	parameter int MAX_KEYS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  kci_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output kci_pkg::result_t result,
	input  logic             active_keys_we,
	input  logic [3:0]       active_keys_wdata
);

	// command and status between the sequencer and the arithmetic
	kci_pkg::cmd_t    cmd;
	kci_pkg::status_t status;

	// sequencer: decode, key scan, multiply / divide steps, result handoff
	kci_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// key store, compare, multipliers, divider and result register
	kci_dp #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.item              (item),
		.active_keys_we    (active_keys_we),
		.active_keys_wdata (active_keys_wdata),
		.cmd               (cmd),
		.status            (status),
		.result            (result)
	);

endmodule

### rtl/kci_div.sv
`timescale 1ns / 1ps
module kci_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [15:0] quotient,
	output logic        done
);

	localparam logic [4:0] LAST_STEP = 5'd31;

	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [16:0] shifted;
	logic [17:0] trial;
	logic        qbit;
	logic [15:0] rem_nx;

	// restoring division, one quotient bit per cycle
	assign shifted = {rem_q, quo_q[31]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor};
	assign qbit    = ~trial[17];
	assign rem_nx  = qbit ? trial[15:0] : shifted[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[30:0], qbit};
		end
	end

	// quotient never exceeds the value step, so 16 bits hold it
	assign quotient = quo_q[15:0];
	assign done     = done_q;

endmodule

### rtl/kci_dp.sv
`timescale 1ns / 1ps
module kci_dp #(
	parameter int MAX_KEYS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  kci_pkg::item_t   item,
	input  logic             active_keys_we,
	input  logic [3:0]       active_keys_wdata,
	input  kci_pkg::cmd_t    cmd,
	output kci_pkg::status_t status,
	output kci_pkg::result_t result
);

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = ($clog2(MAX_KEYS + 1) > 4) ? $clog2(MAX_KEYS + 1) : 4;

	kci_pkg::item_t   item_q;
	kci_pkg::result_t result_q;
	logic [3:0]       active_q;

	logic [15:0] mem_t [MAX_KEYS];
	logic [15:0] mem_v [MAX_KEYS];
	logic [15:0] rd_t_q;
	logic [15:0] rd_v_q;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_nx;
	logic [CW-1:0] act_w;
	logic [CW-1:0] eff;
	logic [CW-1:0] slot_w;
	logic          wr_en;
	logic          rd_en;
	logic [AW-1:0] rd_addr;

	logic [15:0]        prev_t_q;
	logic signed [15:0] prev_v_q;
	logic [CW-1:0]      m_q;
	logic               matched_q;
	logic signed [15:0] v_q;
	logic [15:0]        diff_q;
	logic [15:0]        den_q;
	logic [15:0]        absdv_q;
	logic               neg_q;
	logic [31:0]        num_q;
	logic signed [31:0] prod_q;

	logic [16:0]        dv;
	logic [16:0]        dv_neg;
	logic [31:0]        num_c;
	logic [15:0]        quo;
	logic [17:0]        step;
	logic [17:0]        vsum;
	logic signed [31:0] prod_c;
	logic               div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			idx_q     <= '0;
			matched_q <= 1'b0;
		end else begin
			if (active_keys_we) begin
				active_q <= active_keys_wdata;
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_nx;
			end
			if (cmd.capture) begin
				matched_q <= 1'b0;
			end else if (cmd.take_match) begin
				matched_q <= 1'b1;
			end
		end
	end

	assign act_w  = CW'(active_q);
	assign eff    = (act_w > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : act_w;
	assign slot_w = CW'(item_q.key_slot);
	assign idx_nx = idx_q + CW'(1);

	assign wr_en   = cmd.wr_key && (slot_w < CW'(MAX_KEYS));
	assign rd_en   = cmd.scan_start || cmd.scan_next;
	assign rd_addr = cmd.scan_start ? '0 : idx_nx[AW-1:0];

	// key store, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_t[slot_w[AW-1:0]] <= item_q.key_time;
			mem_v[slot_w[AW-1:0]] <= item_q.key_value;
		end
		if (rd_en) begin
			rd_t_q <= mem_t[rd_addr];
			rd_v_q <= mem_v[rd_addr];
		end
	end

	assign dv     = {rd_v_q[15], rd_v_q} - {prev_v_q[15], prev_v_q};
	assign dv_neg = -dv;
	assign num_c  = absdv_q * diff_q;
	assign step   = neg_q ? -{2'b00, quo} : {2'b00, quo};
	assign vsum   = {{2{prev_v_q[15]}}, prev_v_q} + step;
	assign prod_c = v_q * item_q.origin_value;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.scan_next) begin
			prev_t_q <= rd_t_q;
			prev_v_q <= rd_v_q;
		end
		if (cmd.take_match) begin
			m_q     <= idx_q;
			v_q     <= rd_v_q;
			diff_q  <= item_q.time_ratio - prev_t_q;
			den_q   <= rd_t_q - prev_t_q;
			neg_q   <= dv[16];
			absdv_q <= dv[16] ? dv_neg[15:0] : dv[15:0];
		end
		if (cmd.mul1) begin
			num_q <= num_c;
		end
		if (cmd.fix_v) begin
			v_q <= vsum[15:0];
		end
		if (cmd.mul2) begin
			prod_q <= prod_c;
		end
		if (cmd.load_out) begin
			result_q.curve_result <= matched_q ? prod_q : '0;
			result_q.matched      <= matched_q;
			result_q.matched_slot <= matched_q ? m_q[2:0] : 3'd0;
		end
	end

	kci_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (num_q),
		.divisor  (den_q),
		.quotient (quo),
		.done     (div_done)
	);

	assign status.is_write = (item_q.kind == kci_pkg::KIND_WRITE);
	assign status.too_few  = (eff < CW'(2));
	assign status.hit      = (item_q.time_ratio <= rd_t_q);
	assign status.last     = (idx_nx == eff);
	assign status.direct   = (rd_t_q == 16'd0) || (idx_q == '0) || (rd_t_q == prev_t_q);
	assign status.div_done = div_done;

	assign result = result_q;

endmodule

### rtl/kci_ctrl.sv
`timescale 1ns / 1ps
module kci_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	output logic             result_valid,
	input  logic             result_ready,
	input  kci_pkg::status_t status,
	output kci_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_MUL1   = 4'd3;
	localparam logic [3:0] S_DIVGO  = 4'd4;
	localparam logic [3:0] S_DIVW   = 4'd5;
	localparam logic [3:0] S_FIXV   = 4'd6;
	localparam logic [3:0] S_MUL2   = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       result_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (status.is_write) begin
					cmd.wr_key = 1'b1;
					state_d    = S_FIN;
				end else if (status.too_few) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.hit) begin
					cmd.take_match = 1'b1;
					state_d        = status.direct ? S_MUL2 : S_MUL1;
				end else if (status.last) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (status.div_done) begin
					state_d = S_FIXV;
				end
			end
			S_FIXV: begin
				cmd.fix_v = 1'b1;
				state_d   = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (!result_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == S_DECODE))
		else $error("accepted beat did not move to decode");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == S_DIVW))
		else $error("divider finished outside its wait state");

	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVGO) |=> ((state_q == S_DIVW) && !status.div_done))
		else $error("divider start not followed by a busy wait");

	a_hit_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && status.hit) |=> (state_q == S_MUL1 || state_q == S_MUL2))
		else $error("key hit did not lead to a multiply");

endmodule

### tb/sv/keyframe_curve_interpolator_tb.sv
`timescale 1ns / 1ps
module keyframe_curve_interpolator_tb;

	localparam int MAX_KEYS        = 8;
	// quiet cycles allowed before the run is declared hung
	localparam int STALL_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 64;
	localparam int RANDOM_ROUNDS   = 6;
	localparam int EVALS_PER_ROUND = 72;
	localparam logic [15:0] TIME_ONE = 16'd32768;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	kci_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	kci_pkg::result_t result;
	logic             active_keys_we;
	logic [3:0]       active_keys_wdata;

	// our own copy of the key table and the key count
	logic [15:0]        curve_time [MAX_KEYS];
	logic signed [15:0] curve_value [MAX_KEYS];
	logic [3:0]         curve_count;

	// expected result beats, oldest first
	kci_pkg::result_t pending_curve_beats[$];

	int fault_count;
	int idle_cycles = 0;
	int send_gap_pct;
	int stall_pct;

	keyframe_curve_interpolator #(
		.MAX_KEYS(MAX_KEYS)
	) dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.item             (item),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.result           (result),
		.active_keys_we   (active_keys_we),
		.active_keys_wdata(active_keys_wdata)
	);

	always #2 clk = ~clk;

	// updates the key table on a write beat, otherwise evaluates the curve
	function automatic kci_pkg::result_t curve_for_beat(input kci_pkg::item_t b);
		kci_pkg::result_t r;
		int      n;
		int      m;
		bit      hit;
		longint  tp, tm, vp, vm, v, ratio, origin;
		r = '0;
		if (b.kind == kci_pkg::KIND_WRITE) begin
			curve_time[b.key_slot]  = b.key_time;
			curve_value[b.key_slot] = b.key_value;
			return r;
		end
		// counts above the table size use the whole table
		n = (curve_count > MAX_KEYS) ? MAX_KEYS : int'(curve_count);
		if (n < 2) return r;
		hit = 1'b0;
		m = 0;
		// first key, lowest index, at or above the ratio
		for (int i = 0; i < n; i++) begin
			if (!hit && b.time_ratio <= curve_time[i]) begin
				hit = 1'b1;
				m = i;
			end
		end
		if (!hit) return r;
		ratio  = b.time_ratio;
		origin = $signed(b.origin_value);
		tm = curve_time[m];
		vm = $signed(curve_value[m]);
		v = vm;
		// interpolate unless the key sits at time zero, is the first key, or
		// shares its time with the key before it
		if (tm != 0 && m > 0 && curve_time[m - 1] != curve_time[m]) begin
			tp = curve_time[m - 1];
			vp = $signed(curve_value[m - 1]);
			// quotient truncates toward zero
			if (tm > tp) v = vp + ((ratio - tp) * (vm - vp)) / (tm - tp);
		end
		r.curve_result = 32'(v * origin);
		r.matched      = 1'b1;
		r.matched_slot = 3'(m);
		return r;
	endfunction

	// all fields random and in range; kind random too
	function automatic kci_pkg::item_t random_beat();
		kci_pkg::item_t b;
		b.kind         = 1'($urandom_range(1));
		b.key_slot     = 3'($urandom_range(7));
		b.key_time     = 16'($urandom_range(32768));
		b.key_value    = 16'($urandom);
		b.time_ratio   = 16'($urandom_range(32768));
		b.origin_value = 16'($urandom);
		return b;
	endfunction

	function automatic kci_pkg::item_t key_write(input logic [2:0] slot,
			input logic [15:0] t, input logic signed [15:0] v);
		kci_pkg::item_t b;
		b = random_beat();
		b.kind      = kci_pkg::KIND_WRITE;
		b.key_slot  = slot;
		b.key_time  = t;
		b.key_value = v;
		return b;
	endfunction

	function automatic kci_pkg::item_t curve_eval(input logic [15:0] ratio,
			input logic signed [15:0] origin);
		kci_pkg::item_t b;
		b = random_beat();
		b.kind         = kci_pkg::KIND_EVAL;
		b.time_ratio   = ratio;
		b.origin_value = origin;
		return b;
	endfunction

	// ratios lean toward the ends of the range and onto key times
	function automatic logic [15:0] pick_ratio();
		logic [15:0] t;
		t = curve_time[$urandom_range(MAX_KEYS - 1)];
		case ($urandom_range(9))
			0: return 16'd0;
			1: return TIME_ONE;
			2, 3: return t;
			4: return (t < TIME_ONE) ? t + 16'd1 : t - 16'd1;
			default: return 16'($urandom_range(32768));
		endcase
	endfunction

	function automatic logic signed [15:0] pick_origin();
		case ($urandom_range(7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0100;
			default: return 16'($urandom);
		endcase
	endfunction

	// one item beat; called and returns right after a falling edge, so valid
	// stays high between back-to-back beats
	task automatic send_beat(input kci_pkg::item_t b);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item       <= b;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		pending_curve_beats.push_back(curve_for_beat(b));
		@(negedge clk);
	endtask

	// sender holds off until every expected beat is back
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_curve_beats.size() != 0) @(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	// key count is only changed with the block idle
	task automatic set_key_count(input logic [3:0] n);
		drain_results();
		active_keys_wdata <= n;
		active_keys_we    <= 1'b1;
		@(negedge clk);
		active_keys_we    <= 1'b0;
		curve_count = n;
	endtask

	// fills every slot: mostly rising times with the odd repeated time, now
	// and then a scrambled table
	task automatic load_random_curve();
		int tv;
		bit scrambled;
		scrambled = ($urandom_range(4) == 0);
		tv = ($urandom_range(2) == 0) ? 0 : $urandom_range(4000);
		for (int k = 0; k < MAX_KEYS; k++) begin
			if (scrambled) begin
				tv = $urandom_range(32768);
			end else if (k > 0 && $urandom_range(5) != 0) begin
				tv = tv + $urandom_range(1, 9000);
				if (tv > 32768) tv = 32768;
			end
			if (!scrambled && k == MAX_KEYS - 1 && $urandom_range(1) == 1) tv = 32768;
			send_beat(key_write(3'(k), 16'(tv), 16'($urandom)));
		end
	endtask

	// whole table written before anything reads it; extremes of time and value
	task automatic test_key_table_load();
		send_beat(key_write(3'd0, 16'd0,     16'sh1000));
		send_beat(key_write(3'd1, 16'd4096,  16'sh8000));
		send_beat(key_write(3'd2, 16'd8192,  16'sh7fff));
		send_beat(key_write(3'd3, 16'd8192,  16'sh0800));
		send_beat(key_write(3'd4, 16'd16384, 16'shf000));
		send_beat(key_write(3'd5, 16'd24576, 16'sh2000));
		send_beat(key_write(3'd6, 16'd30000, 16'sh0064));
		send_beat(key_write(3'd7, TIME_ONE,  16'shffff));
	endtask

	// zero keys straight out of reset, then a single key
	task automatic test_too_few_keys();
		send_beat(curve_eval(16'd2048, 16'sh0100));
		set_key_count(4'd1);
		send_beat(curve_eval(16'd0, 16'sh0100));
	endtask

	task automatic test_direct_and_interpolated();
		set_key_count(4'd8);
		send_beat(curve_eval(16'd0,     16'sh7fff));  // key at time zero
		send_beat(curve_eval(16'd2048,  16'sh8000));
		send_beat(curve_eval(16'd8192,  16'sh0100));  // exactly on a key
		send_beat(curve_eval(16'd12000, 16'sh7fff));  // past the repeated time
		send_beat(curve_eval(TIME_ONE,  16'sh8000));
		send_beat(curve_eval(16'd30000, 16'sh0001));
		send_beat(curve_eval(16'd4097,  16'shffff));
	endtask

	// ratio above every active key
	task automatic test_no_match();
		set_key_count(4'd4);
		send_beat(curve_eval(TIME_ONE, 16'sh0100));
		send_beat(curve_eval(16'd8193, 16'sh7fff));
	endtask

	task automatic test_ratio_below_first_key();
		set_key_count(4'd8);
		send_beat(key_write(3'd0, 16'd1000, 16'sh7fff));
		send_beat(curve_eval(16'd500,  16'sh8000));
		send_beat(curve_eval(16'd1000, 16'sh7fff));
	endtask

	task automatic test_random_curves(input int gap_pct, input int stall_rate);
		int keys;
		int pick;
		send_gap_pct = gap_pct;
		stall_pct    = stall_rate;
		for (int r = 0; r < RANDOM_ROUNDS; r++) begin
			case (r)
				0: keys = 8;
				1: keys = 2;
				2: keys = $urandom_range(1);
				3: keys = $urandom_range(3, 7);
				default: keys = $urandom_range(2, 8);
			endcase
			set_key_count(4'(keys));
			load_random_curve();
			for (int e = 0; e < EVALS_PER_ROUND; e++) begin
				pick = $urandom_range(99);
				// a key rewritten in the middle of a curve
				if (pick < 8) begin
					send_beat(key_write(3'($urandom_range(7)), 16'($urandom_range(32768)),
						16'($urandom)));
				end else if (pick < 10) begin
					send_beat(random_beat());
				end else begin
					send_beat(curve_eval(pick_ratio(), pick_origin()));
				end
				if ($urandom_range(49) == 0) drain_results();
			end
		end
	endtask

	// receiver stalls at random
	always @(negedge clk) begin
		result_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// every result beat against the oldest expectation
	always @(posedge clk) begin : check_results
		kci_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_curve_beats.size() == 0) begin
				$error("result beat with no evaluation pending");
				fault_count++;
			end else begin
				want = pending_curve_beats.pop_front();
				if (result.curve_result !== want.curve_result) begin
					$error("curve_result: expected %0d, got %0d",
						want.curve_result, result.curve_result);
					fault_count++;
				end
				if (result.matched !== want.matched) begin
					$error("matched: expected %0d, got %0d", want.matched, result.matched);
					fault_count++;
				end
				if (result.matched_slot !== want.matched_slot) begin
					$error("matched_slot: expected %0d, got %0d",
						want.matched_slot, result.matched_slot);
					fault_count++;
				end
			end
		end
	end

	// hang detection: too long without a beat on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n            = 1'b0;
		item_valid        = 1'b0;
		item              = '0;
		result_ready      = 1'b0;
		active_keys_we    = 1'b0;
		active_keys_wdata = '0;
		curve_count       = '0;
		fault_count       = 0;
		send_gap_pct      = 0;
		stall_pct         = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_key_table_load();
		test_too_few_keys();
		test_direct_and_interpolated();
		test_no_match();
		test_ratio_below_first_key();

		// idling phases: none, sender only, receiver only, both
		test_random_curves(0, 0);
		test_random_curves(46, 0);
		test_random_curves(0, 46);
		test_random_curves(33, 33);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
